[rtl/core/pxsc_pkg.sv]
// Shared types and constants of the packet XOR and swap cipher.
package pxsc_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 13;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned KEY_W       = 64;

   // Reciprocal scaling for division of a packet length by a small constant.
   localparam int unsigned RECIP_SHIFT = 18;
   localparam int unsigned RECIP_W     = 18;

   // Register select, taken from the top address bit (registers are 8 bytes apart).
   localparam logic CSR_KEY = 1'b0;
   localparam logic CSR_DIR = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  packet_length;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              packet_end;
      logic              run_last;
      logic              length_error;
   } rsp_payload_type;

endpackage

[rtl/core/packet_xor_swap_cipher.sv]
// Top level of the packet XOR and swap cipher: length pipeline, block control and output stage.
//
// Input items (req_) carry one packet byte and the packet's total length. Result items
// (rsp_) carry one transformed byte each. An item that completes a block of B bytes
// yields B results, one per cycle while the receiver is ready; a tail byte or a rejected
// length yields one result; other items yield none and are simply buffered.
// The key and the direction are written through the APB-style csr_ port: the key at
// byte address 0, the direction at byte address 8. pready is always high.
// An item passes through the stage 1 and stage 2 registers to the block control, and a
// result it causes is then loaded into the output register.
// Throughput: one item per cycle unless an item waits for the output register. A block's
// results leave at one per cycle from the output register while the receiver is ready and
// the next block fills, so items that only fill blocks never wait; a tail byte or a rejected
// item that follows a block waits until that block has drained.
// When the receiver stalls, the output register holds its result; items keep entering
// until an item that needs the output register meets a busy one, then req_ready drops.
// Reset clears the pipeline, the packet position and both configuration registers.
// The block buffer needs no clearing pass after reset.
module packet_xor_swap_cipher #(
   parameter int unsigned KEY_BYTES  = 8,
   parameter int unsigned MAX_PACKET = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pxsc_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pxsc_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pxsc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pxsc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pxsc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned LEN_W       = pxsc_pkg::LEN_W;
   localparam int unsigned BYTE_W      = pxsc_pkg::BYTE_W;
   localparam int unsigned PROD_W      = pxsc_pkg::LEN_W + pxsc_pkg::RECIP_W;
   localparam int unsigned NCAND       = KEY_BYTES / 2 + 1;
   localparam int unsigned MOD_DIV     = KEY_BYTES / 2 + 1;
   localparam int unsigned MOD_RCP     =
      ((1 << pxsc_pkg::RECIP_SHIFT) + MOD_DIV - 1) / MOD_DIV;
   localparam int unsigned STORE_DEPTH = 2 * KEY_BYTES;
   localparam int unsigned FILL_W      = $clog2(STORE_DEPTH);
   localparam int unsigned BLK_W       = $clog2(STORE_DEPTH + 1);
   localparam int unsigned SWAP_W      = $clog2(KEY_BYTES + 1);
   localparam int unsigned KIDX_W      = $clog2(KEY_BYTES);
   localparam int unsigned POS_W       = $clog2(MAX_PACKET);
   localparam int unsigned CAND_W      = $clog2(NCAND);

   // ---------------------------------------------------------------- configuration
   logic [pxsc_pkg::KEY_W-1:0] key_ff;
   logic                       dir_ff;
   logic                       csr_write;
   logic                       csr_sel;
   logic [BYTE_W-1:0]          key_bytes [KEY_BYTES];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[pxsc_pkg::CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         dir_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_sel)
            pxsc_pkg::CSR_KEY: key_ff <= csr_pwdata;
            pxsc_pkg::CSR_DIR: dir_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[pxsc_pkg::CSR_ADDR_W-2:0] == '0) begin
         case (csr_sel)
            pxsc_pkg::CSR_KEY: csr_prdata = key_ff;
            pxsc_pkg::CSR_DIR: csr_prdata = pxsc_pkg::CSR_DATA_W'(dir_ff);
            default:           csr_prdata = '0;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < KEY_BYTES; i++) begin
         key_bytes[i] = key_ff[8*i +: 8];
      end
   end

   // ---------------------------------------------------------------- handshake
   logic req_fire;
   logic s1_valid_ff, s1_valid_in, s1_adv;
   logic s2_valid_ff, s2_valid_in, s2_adv;
   logic o_valid_ff, o_valid_in;
   logic out_free, last_beat, rsp_fire, o_load;
   logic produces;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign out_free    = !o_valid_ff || (rsp_ready && last_beat);
   assign s2_adv      = s2_valid_ff && (!produces || out_free);
   assign s1_adv      = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign o_load      = s2_adv && produces;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_adv);
   assign o_valid_in  = o_load || (o_valid_ff && !(rsp_fire && last_beat));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: quotients
   // Quotients by the small divisors come from reciprocal products, which are exact
   // for every 13-bit length at this scaling.
   logic [LEN_W-1:0]  quot_s0 [NCAND];
   logic [LEN_W-1:0]  quot_mod_s0;
   logic [PROD_W-1:0] prod_mod_s0;
   logic              bad_s0;

   logic [BYTE_W-1:0] s1_byte_ff;
   logic [LEN_W-1:0]  s1_len_ff;
   logic              s1_bad_ff;
   logic [LEN_W-1:0]  s1_quot_ff [NCAND];
   logic [LEN_W-1:0]  s1_quot_mod_ff;
   logic [LEN_W-1:0]  rem_cand [NCAND];

   for (genvar gi = 0; gi < NCAND; gi++) begin : g_cand
      localparam int unsigned DIV = 2 * gi + KEY_BYTES;
      localparam int unsigned RCP = ((1 << pxsc_pkg::RECIP_SHIFT) + DIV - 1) / DIV;
      logic [PROD_W-1:0] prod;
      assign prod          = PROD_W'(req_payload.packet_length) * PROD_W'(RCP);
      assign quot_s0[gi]   = prod[pxsc_pkg::RECIP_SHIFT +: LEN_W];
      assign rem_cand[gi]  = s1_len_ff - LEN_W'(s1_quot_ff[gi] * LEN_W'(DIV));
   end

   assign prod_mod_s0 = PROD_W'(req_payload.packet_length) * PROD_W'(MOD_RCP);
   assign quot_mod_s0 = prod_mod_s0[pxsc_pkg::RECIP_SHIFT +: LEN_W];
   assign bad_s0      = (req_payload.packet_length == '0) ||
                        ({1'b0, req_payload.packet_length} > (LEN_W+1)'(MAX_PACKET));

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff     <= req_payload.data_byte;
         s1_len_ff      <= req_payload.packet_length;
         s1_bad_ff      <= bad_s0;
         s1_quot_ff     <= quot_s0;
         s1_quot_mod_ff <= quot_mod_s0;
      end
   end

   // ---------------------------------------------------------------- stage 2: block size
   logic [LEN_W-1:0]  rem_mod;
   logic [CAND_W-1:0] cand_sel;
   logic [BLK_W-1:0]  blk_s1;
   logic [LEN_W-1:0]  tail_s1;

   assign rem_mod  = s1_len_ff - LEN_W'(s1_quot_mod_ff * LEN_W'(MOD_DIV));
   assign cand_sel = CAND_W'(rem_mod);
   assign blk_s1   = BLK_W'({cand_sel, 1'b0}) + BLK_W'(KEY_BYTES);
   assign tail_s1  = s1_len_ff - rem_cand[cand_sel];

   logic [BYTE_W-1:0] s2_byte_ff;
   logic [LEN_W-1:0]  s2_len_ff;
   logic              s2_bad_ff;
   logic [BLK_W-1:0]  s2_blk_ff;
   logic [LEN_W-1:0]  s2_tail_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_byte_ff <= s1_byte_ff;
         s2_len_ff  <= s1_len_ff;
         s2_bad_ff  <= s1_bad_ff;
         s2_blk_ff  <= blk_s1;
         s2_tail_ff <= tail_s1;
      end
   end

   // ---------------------------------------------------------------- block control
   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_eff;
   logic [SWAP_W-1:0] swap_ff, swap_in, swap_eff, swap_sel, swap_next;
   logic [KIDX_W-1:0] kmod_ff, kmod_in, kmod_eff, kmod_inc;
   logic [KIDX_W-1:0] start_mod_ff, start_mod_in, base_mod;
   logic [BYTE_W-1:0] store_ff [STORE_DEPTH];
   logic [BYTE_W-1:0] snap [STORE_DEPTH];
   logic              overrun, is_last, in_tail, blk_done, store_we;
   logic [LEN_W:0]    pos_len;
   logic [BLK_W-1:0]  fill_inc, half, swap_inc;
   logic [BYTE_W-1:0] key_now;

   always_comb begin
      overrun  = {1'b0, LEN_W'(pos_ff)} >= {1'b0, s2_len_ff};
      pos_eff  = overrun ? '0 : pos_ff;
      fill_eff = overrun ? '0 : fill_ff;
      swap_eff = overrun ? '0 : swap_ff;
      kmod_eff = overrun ? '0 : kmod_ff;
      pos_len  = (LEN_W+1)'(pos_eff);
      is_last  = (pos_len + (LEN_W+1)'(1)) == {1'b0, s2_len_ff};
      in_tail  = pos_len >= {1'b0, s2_tail_ff};
      key_now  = key_bytes[kmod_eff];
      fill_inc = BLK_W'(fill_eff) + BLK_W'(1);
      blk_done = !in_tail && (fill_inc >= s2_blk_ff);
      produces = s2_bad_ff || in_tail || blk_done;
      half     = s2_blk_ff >> 1;
      swap_sel = (BLK_W'(swap_eff) > half) ? '0 : swap_eff;
      swap_inc = BLK_W'(swap_sel) + BLK_W'(1);
      swap_next = (swap_inc > half) ? '0 : SWAP_W'(swap_inc);
      base_mod = (fill_eff == '0) ? kmod_eff : start_mod_ff;
      kmod_inc = (kmod_eff == KIDX_W'(KEY_BYTES - 1)) ? '0 : kmod_eff + KIDX_W'(1);
      store_we = s2_adv && !s2_bad_ff && !in_tail;

      for (int i = 0; i < STORE_DEPTH; i++) begin
         snap[i] = (FILL_W'(i) == fill_eff) ? s2_byte_ff : store_ff[i];
      end

      pos_in       = pos_ff;
      fill_in      = fill_ff;
      swap_in      = swap_ff;
      kmod_in      = kmod_ff;
      start_mod_in = start_mod_ff;
      if (s2_adv && !s2_bad_ff) begin
         pos_in  = pos_eff;
         fill_in = fill_eff;
         swap_in = swap_eff;
         kmod_in = kmod_eff;
         if (in_tail) begin
            fill_in = '0;
         end else begin
            start_mod_in = base_mod;
            if (blk_done) begin
               fill_in = '0;
               swap_in = swap_next;
            end else begin
               fill_in = FILL_W'(fill_inc);
            end
         end
         if (is_last) begin
            pos_in  = '0;
            fill_in = '0;
            swap_in = '0;
            kmod_in = '0;
         end else begin
            pos_in  = POS_W'(pos_len + (LEN_W+1)'(1));
            kmod_in = kmod_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         swap_ff <= '0;
         kmod_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
         swap_ff <= swap_in;
         kmod_ff <= kmod_in;
      end
   end

   always_ff @(posedge clock) begin
      start_mod_ff <= start_mod_in;
      if (store_we) begin
         store_ff[fill_eff] <= s2_byte_ff;
      end
   end

   // ---------------------------------------------------------------- output stage
   // A finished block is copied here whole, so the buffer above can take the next
   // block while this one drains. A single result is held as a block of one.
   logic [BYTE_W-1:0] o_buf_ff [STORE_DEPTH];
   logic [BLK_W-1:0]  o_blk_ff;
   logic [SWAP_W-1:0] o_r_ff;
   logic [FILL_W-1:0] o_beat_ff;
   logic [KIDX_W-1:0] o_kidx_ff;
   logic              o_xor_ff, o_dir_ff, o_end_ff, o_err_ff;
   logic [BLK_W-1:0]  beat_b, mirror, sel;
   logic [BLK_W:0]    kidx_sum;
   logic [KIDX_W-1:0] kidx;
   logic [BYTE_W-1:0] out_byte;

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_beat_ff <= '0;
         if (s2_bad_ff) begin
            o_buf_ff[0] <= '0;
            o_blk_ff    <= BLK_W'(1);
            o_r_ff      <= '0;
            o_kidx_ff   <= '0;
            o_xor_ff    <= 1'b0;
            o_dir_ff    <= 1'b0;
            o_end_ff    <= 1'b0;
            o_err_ff    <= 1'b1;
         end else if (in_tail) begin
            o_buf_ff[0] <= s2_byte_ff ^ key_now;
            o_blk_ff    <= BLK_W'(1);
            o_r_ff      <= '0;
            o_kidx_ff   <= '0;
            o_xor_ff    <= 1'b0;
            o_dir_ff    <= 1'b0;
            o_end_ff    <= is_last;
            o_err_ff    <= 1'b0;
         end else begin
            o_buf_ff    <= snap;
            o_blk_ff    <= s2_blk_ff;
            o_r_ff      <= swap_sel;
            o_kidx_ff   <= base_mod;
            o_xor_ff    <= 1'b1;
            o_dir_ff    <= dir_ff;
            o_end_ff    <= is_last;
            o_err_ff    <= 1'b0;
         end
      end else if (rsp_fire && !last_beat) begin
         o_beat_ff <= o_beat_ff + FILL_W'(1);
      end
   end

   always_comb begin
      beat_b    = BLK_W'(o_beat_ff);
      last_beat = (beat_b + BLK_W'(1)) == o_blk_ff;
      mirror    = o_blk_ff - BLK_W'(1) - BLK_W'(o_r_ff);
      if (beat_b == BLK_W'(o_r_ff)) begin
         sel = mirror;
      end else if (beat_b == mirror) begin
         sel = BLK_W'(o_r_ff);
      end else begin
         sel = beat_b;
      end
      // Encryption keys a buffered byte at its input position, decryption at its
      // output position after the swap.
      kidx_sum = (BLK_W+1)'(o_kidx_ff) + (o_dir_ff ? {1'b0, beat_b} : {1'b0, sel});
      if (kidx_sum >= (BLK_W+1)'(2 * KEY_BYTES)) begin
         kidx = KIDX_W'(kidx_sum - (BLK_W+1)'(2 * KEY_BYTES));
      end else if (kidx_sum >= (BLK_W+1)'(KEY_BYTES)) begin
         kidx = KIDX_W'(kidx_sum - (BLK_W+1)'(KEY_BYTES));
      end else begin
         kidx = KIDX_W'(kidx_sum);
      end
      out_byte = o_buf_ff[FILL_W'(sel)] ^ (o_xor_ff ? key_bytes[kidx] : '0);
   end

   assign rsp_valid                = o_valid_ff;
   assign rsp_payload.out_byte     = out_byte;
   assign rsp_payload.packet_end   = o_end_ff && last_beat;
   assign rsp_payload.run_last     = last_beat;
   assign rsp_payload.length_error = o_err_ff;

   // ---------------------------------------------------------------- assertions
   a_beat_in_block: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (BLK_W'(o_beat_ff) < o_blk_ff))
      else $error("output beat runs past the end of its block");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.length_error) |->
         (rsp_payload.run_last && !rsp_payload.packet_end && rsp_payload.out_byte == '0))
      else $error("rejected item result is not a lone empty item");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && o_valid_ff))
      else $error("input stalled without a full pipeline and busy output");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (LEN_W+1)'(pos_ff) < (LEN_W+1)'(MAX_PACKET))
      else $error("packet position beyond the largest packet");

endmodule
